// ===== rtl/core/lpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pixel frame buffer package
// Shared widths, constants and encodings for the frame buffer core and its
// brightness scaling unit.
// ----------------------------------------------------------------------------
package lpfb_pkg;

  // Widths of one colour channel, a packed pixel word and the gain register.
  localparam int unsigned ColorW = 8;
  localparam int unsigned WordW  = 24;
  localparam int unsigned GainW  = 9;

  // Gain value that stands for 1.0.
  localparam logic [GainW-1:0] FullScale = 9'd256;

  // Action codes carried by an input word.
  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_CLEAR = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_LATCH = 3'd3,
    ACT_SEND  = 3'd4
  } lpfb_action_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LATCH,
    ST_SEND
  } lpfb_state_e;

  // Sub-steps used while one pixel is scaled and stored.
  typedef enum logic [2:0] {
    STEP_HUE,
    STEP_GREEN,
    STEP_RED,
    STEP_BLUE,
    STEP_STORE
  } lpfb_step_e;

endpackage

// ===== rtl/core/lpfb_scale_unit.sv =====
// ----------------------------------------------------------------------------
// Brightness scaling unit
// Multiplies one colour channel by the gain and keeps the integer part of the
// product in a register, one channel per clock cycle.
// ----------------------------------------------------------------------------
module lpfb_scale_unit (
  input  logic                         clk_i,
  input  logic [lpfb_pkg::ColorW-1:0]  color_i,
  input  logic [lpfb_pkg::GainW-1:0]   gain_i,
  output logic [lpfb_pkg::ColorW-1:0]  scaled_o
);

  // The gain never exceeds 1.0, so the product fits in 16 bits.
  logic [2*lpfb_pkg::ColorW-1:0] product;
  logic [lpfb_pkg::ColorW-1:0]   scaled_q;

  // Full product, then drop the eight fraction bits.
  always_comb begin
    product = (2*lpfb_pkg::ColorW)'({8'd0, color_i} * {7'd0, gain_i});
  end

  // Result register in front of the sequencer.
  always_ff @(posedge clk_i) begin
    scaled_q <= product[2*lpfb_pkg::ColorW-1:lpfb_pkg::ColorW];
  end

  assign scaled_o = scaled_q;

endmodule

// ===== rtl/core/led_pixel_frame_buffer_core.sv =====
// ----------------------------------------------------------------------------
// LED pixel frame buffer core
// Drawing and output buffers of packed green/red/blue words with brightness
// scaling, rainbow fill, latch and frame send.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; busy_o stays
// high until the command has finished. Steps per command with N pixels:
// write pixel passes each colour through the single shared 8x9 scaling
// multiplier, then stores; clear is done in the idle state; rainbow fill runs
// a hue step, three multiplier passes and a store for each pixel; latch and
// send frame each read the source buffer once per pixel through its one read
// port. A send puts one word per cycle on the result ports, marked by
// out_strobe_o, for exactly one cycle each; the receiver cannot stall them.
// Both buffers read as zero after reset without a clearing pass. brightness
// is written through the cfg channel, which is always ready and must only be
// used while busy_o is low.
// ----------------------------------------------------------------------------
module led_pixel_frame_buffer_core #(
  parameter int unsigned PIXEL_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    action_i,
  input  logic [7:0]                    pixel_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    phase_i,
  // Brightness register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpfb_pkg::GainW-1:0]    cfg_data_i,
  // Result words
  output logic                          out_strobe_o,
  output logic [lpfb_pkg::WordW-1:0]    pixel_word_o,
  output logic [5:0]                    pixel_position_o,
  output logic                          last_word_o
);

  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(PIXEL_COUNT - 1);
  // Per-pixel hue increment 256/N, split into quotient and remainder.
  localparam int unsigned HueQuot = 256 / PIXEL_COUNT;
  localparam int unsigned HueRem  = 256 % PIXEL_COUNT;
  localparam logic [7:0] HueQuotStep = 8'(HueQuot);
  localparam logic [7:0] HueRemStep  = 8'(HueRem);
  localparam logic [7:0] PixelCount8 = 8'(PIXEL_COUNT);
  localparam logic [7:0] HueSeg1 = 8'd85;
  localparam logic [7:0] HueSeg2 = 8'd170;
  localparam logic [7:0] ColorMax = 8'd255;

  // Three-segment colour wheel, packed green/red/blue before scaling.
  function automatic logic [23:0] rainbow_color(input logic [7:0] hue);
    logic [7:0] h;
    logic [9:0] trip;
    logic [7:0] up;
    logic [7:0] dn;
    logic [23:0] res;
    if (hue < HueSeg1) begin
      h = hue;
    end else if (hue < HueSeg2) begin
      h = hue - HueSeg1;
    end else begin
      h = hue - HueSeg2;
    end
    trip = {2'b00, h} * 10'd3;
    up   = trip[7:0];
    dn   = ColorMax - up;
    if (hue < HueSeg1) begin
      res = {up, dn, 8'd0};
    end else if (hue < HueSeg2) begin
      res = {dn, 8'd0, up};
    end else begin
      res = {8'd0, up, dn};
    end
    return res;
  endfunction

  lpfb_pkg::lpfb_state_e state_q, state_d;
  lpfb_pkg::lpfb_step_e  step_q;
  lpfb_pkg::lpfb_action_e action;

  logic                        accept;
  logic                        in_range;
  logic                        cnt_last;
  logic [AW-1:0]               cnt_q;
  logic                        fill_q;
  logic [7:0]                  phase_q;
  logic [7:0]                  hue_off_q;
  logic [7:0]                  hue_rem_q;
  logic [7:0]                  rem_sum;
  logic [23:0]                 color_q;
  logic [15:0]                 acc_q;
  logic [lpfb_pkg::GainW-1:0]  brightness_q;
  logic [lpfb_pkg::GainW-1:0]  gain;
  logic [lpfb_pkg::ColorW-1:0] feed;
  logic [lpfb_pkg::ColorW-1:0] scaled;

  logic [PIXEL_COUNT-1:0]      draw_valid_q;
  logic [PIXEL_COUNT-1:0]      out_valid_q;
  logic [lpfb_pkg::WordW-1:0]  draw_mem [PIXEL_COUNT];
  logic [lpfb_pkg::WordW-1:0]  out_mem  [PIXEL_COUNT];
  logic [lpfb_pkg::WordW-1:0]  draw_rd_q;
  logic [lpfb_pkg::WordW-1:0]  out_rd_q;
  logic                        draw_we;
  logic                        lat_rd;
  logic                        send_rd;
  logic                        lat_pend_q;
  logic                        send_pend_q;
  logic [AW-1:0]               lat_addr_q;
  logic [AW-1:0]               send_addr_q;

  assign action   = lpfb_pkg::lpfb_action_e'(action_i);
  assign accept   = start_i && !busy_o;
  assign in_range = pixel_index_i < PixelCount8;
  assign cnt_last = cnt_q == LastAddr;
  assign rem_sum  = hue_rem_q + HueRemStep;
  assign gain     = (brightness_q > lpfb_pkg::FullScale) ? lpfb_pkg::FullScale
                                                         : brightness_q;

  // Shared multiplier for every colour that is written.
  lpfb_scale_unit u_scale (
    .clk_i    (clk_i),
    .color_i  (feed),
    .gain_i   (gain),
    .scaled_o (scaled)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpfb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (action)
            lpfb_pkg::ACT_WRITE: if (in_range) state_d = lpfb_pkg::ST_SCALE;
            lpfb_pkg::ACT_FILL:  state_d = lpfb_pkg::ST_SCALE;
            lpfb_pkg::ACT_LATCH: state_d = lpfb_pkg::ST_LATCH;
            lpfb_pkg::ACT_SEND:  state_d = lpfb_pkg::ST_SEND;
            default:             state_d = lpfb_pkg::ST_IDLE;
          endcase
        end
      end
      lpfb_pkg::ST_SCALE: begin
        if (step_q == lpfb_pkg::STEP_STORE && (!fill_q || cnt_last)) begin
          state_d = lpfb_pkg::ST_IDLE;
        end
      end
      lpfb_pkg::ST_LATCH, lpfb_pkg::ST_SEND: begin
        if (cnt_last) state_d = lpfb_pkg::ST_IDLE;
      end
      default: state_d = lpfb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    busy_o  = (state_q != lpfb_pkg::ST_IDLE) || lat_pend_q || send_pend_q;
    draw_we = (state_q == lpfb_pkg::ST_SCALE) && (step_q == lpfb_pkg::STEP_STORE);
    lat_rd  = state_q == lpfb_pkg::ST_LATCH;
    send_rd = state_q == lpfb_pkg::ST_SEND;
    unique case (step_q)
      lpfb_pkg::STEP_GREEN: feed = color_q[23:16];
      lpfb_pkg::STEP_RED:   feed = color_q[15:8];
      lpfb_pkg::STEP_BLUE:  feed = color_q[7:0];
      default:              feed = '0;
    endcase
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lpfb_pkg::ST_IDLE;
      step_q       <= lpfb_pkg::STEP_HUE;
      cnt_q        <= '0;
      fill_q       <= 1'b0;
      lat_pend_q   <= 1'b0;
      send_pend_q  <= 1'b0;
      brightness_q <= lpfb_pkg::FullScale;
      draw_valid_q <= '0;
      out_valid_q  <= '0;
    end else begin
      state_q     <= state_d;
      lat_pend_q  <= lat_rd;
      send_pend_q <= send_rd;
      if (cfg_valid_i && cfg_ready_o) begin
        brightness_q <= cfg_data_i;
      end
      if (draw_we) begin
        draw_valid_q[cnt_q] <= 1'b1;
      end
      if (state_q == lpfb_pkg::ST_IDLE && accept) begin
        unique case (action)
          lpfb_pkg::ACT_WRITE: begin
            cnt_q  <= pixel_index_i[AW-1:0];
            fill_q <= 1'b0;
            step_q <= lpfb_pkg::STEP_GREEN;
          end
          lpfb_pkg::ACT_CLEAR: draw_valid_q <= '0;
          lpfb_pkg::ACT_FILL: begin
            cnt_q  <= '0;
            fill_q <= 1'b1;
            step_q <= lpfb_pkg::STEP_HUE;
          end
          lpfb_pkg::ACT_LATCH: begin
            cnt_q       <= '0;
            out_valid_q <= draw_valid_q;
          end
          lpfb_pkg::ACT_SEND: cnt_q <= '0;
          default: ;
        endcase
      end else if (state_q == lpfb_pkg::ST_SCALE) begin
        unique case (step_q)
          lpfb_pkg::STEP_HUE:   step_q <= lpfb_pkg::STEP_GREEN;
          lpfb_pkg::STEP_GREEN: step_q <= lpfb_pkg::STEP_RED;
          lpfb_pkg::STEP_RED:   step_q <= lpfb_pkg::STEP_BLUE;
          lpfb_pkg::STEP_BLUE:  step_q <= lpfb_pkg::STEP_STORE;
          default: begin
            step_q <= lpfb_pkg::STEP_HUE;
            if (fill_q && !cnt_last) cnt_q <= cnt_q + 1'b1;
          end
        endcase
      end else if ((lat_rd || send_rd) && !cnt_last) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Colour, hue and word assembly registers.
  always_ff @(posedge clk_i) begin
    if (state_q == lpfb_pkg::ST_IDLE && accept) begin
      color_q   <= {green_i, red_i, blue_i};
      phase_q   <= phase_i;
      hue_off_q <= '0;
      hue_rem_q <= '0;
    end else if (state_q == lpfb_pkg::ST_SCALE) begin
      unique case (step_q)
        lpfb_pkg::STEP_HUE:  color_q <= rainbow_color(phase_q + hue_off_q);
        lpfb_pkg::STEP_RED:  acc_q[15:8] <= scaled;
        lpfb_pkg::STEP_BLUE: acc_q[7:0] <= scaled;
        lpfb_pkg::STEP_STORE: begin
          // Advance the hue offset by 256/N with an exact remainder.
          if (rem_sum >= PixelCount8) begin
            hue_rem_q <= rem_sum - PixelCount8;
            hue_off_q <= hue_off_q + HueQuotStep + 8'd1;
          end else begin
            hue_rem_q <= rem_sum;
            hue_off_q <= hue_off_q + HueQuotStep;
          end
        end
        default: ;
      endcase
    end
  end

  // Drawing buffer: scaled words in, latch reads out.
  always_ff @(posedge clk_i) begin
    if (draw_we) begin
      draw_mem[cnt_q] <= {acc_q, scaled};
    end
    if (lat_rd) begin
      draw_rd_q <= draw_mem[cnt_q];
    end
  end

  // Output buffer: latch writes in, send reads out.
  always_ff @(posedge clk_i) begin
    if (lat_pend_q) begin
      out_mem[lat_addr_q] <= draw_rd_q;
    end
    if (send_rd) begin
      out_rd_q <= out_mem[cnt_q];
    end
  end

  // Addresses that travel with the registered reads.
  always_ff @(posedge clk_i) begin
    lat_addr_q  <= cnt_q;
    send_addr_q <= cnt_q;
  end

  // Result word, shown in the cycle after its read.
  assign cfg_ready_o      = 1'b1;
  assign out_strobe_o     = send_pend_q;
  assign pixel_word_o     = out_valid_q[send_addr_q] ? out_rd_q : '0;
  assign pixel_position_o = 6'(send_addr_q);
  assign last_word_o      = send_pend_q && (send_addr_q == LastAddr);

`ifndef SYNTHESIS
  // A result word only appears while a command is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_strobe_o |-> busy_o)
    else $error("result word outside of a command");

  // The last-word mark only rides on a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni) last_word_o |-> out_strobe_o)
    else $error("last word mark without a result word");

  // Frame words come back to back until the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_word_o |=> out_strobe_o)
    else $error("gap inside a frame");

  // An accepted send keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action == lpfb_pkg::ACT_SEND |=> busy_o && !out_strobe_o)
    else $error("send command did not start");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel frame buffer core testbench
// Drives write, clear, rainbow fill, latch and send commands with random
// pacing, and changes the brightness gain between phases. A scoreboard keeps
// its own drawing and output buffers, works out every frame a send should
// emit, and checks each strobed word against it in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PIXEL_COUNT = 16;
  // Highest code the 3-bit action field can carry; codes above send are unused.
  localparam logic [2:0] ActCodeMax = 3'd7;
  // A rainbow fill is the longest command; let it finish before a gain change.
  localparam int unsigned SettleCycles = 5 * PIXEL_COUNT + 8;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 56;

  // One emitted frame word.
  typedef struct packed {
    logic [lpfb_pkg::WordW-1:0] word;
    logic [5:0]                 position;
    logic                       last;
  } frame_word_t;

  // Frame buffer scoreboard: its own copy of both buffers and the gain.
  class frame_scoreboard;
    logic [lpfb_pkg::WordW-1:0] drawing [PIXEL_COUNT];
    logic [lpfb_pkg::WordW-1:0] shown [PIXEL_COUNT];
    logic [lpfb_pkg::GainW-1:0] gain;
    frame_word_t                frame_words [$];
    int unsigned                mismatches;
    int unsigned                words_seen;

    function new();
      foreach (drawing[i]) begin
        drawing[i] = '0;
        shown[i] = '0;
      end
      gain = lpfb_pkg::FullScale;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void set_gain(logic [lpfb_pkg::GainW-1:0] value);
      gain = value;
    endfunction

    function int unsigned pending();
      return frame_words.size();
    endfunction

    // Gains above full scale act as full scale; the product is truncated.
    function logic [lpfb_pkg::ColorW-1:0] scale_channel(int unsigned c);
      int unsigned k;
      k = (gain > lpfb_pkg::FullScale) ? lpfb_pkg::FullScale : gain;
      return (lpfb_pkg::ColorW)'((c * k) >> 8);
    endfunction

    function logic [lpfb_pkg::WordW-1:0] pack_pixel(int unsigned r, int unsigned g,
                                                    int unsigned b);
      return {scale_channel(g), scale_channel(r), scale_channel(b)};
    endfunction

    // Three-segment colour wheel, each pixel offset by an equal share of 256.
    function void fill_wheel(logic [7:0] phase);
      int unsigned h;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      for (int unsigned i = 0; i < PIXEL_COUNT; i++) begin
        h = (phase + i * 256 / PIXEL_COUNT) % 256;
        if (h < 85) begin
          r = 255 - 3 * h;
          g = 3 * h;
          b = 0;
        end else if (h < 170) begin
          h = h - 85;
          r = 0;
          g = 255 - 3 * h;
          b = 3 * h;
        end else begin
          h = h - 170;
          r = 3 * h;
          g = 0;
          b = 255 - 3 * h;
        end
        drawing[i] = pack_pixel(r, g, b);
      end
    endfunction

    // Applies one accepted command and queues the words a send produces.
    function void note_command(logic [2:0] action, logic [7:0] index, logic [7:0] red,
                               logic [7:0] green, logic [7:0] blue, logic [7:0] phase);
      frame_word_t fw;
      case (action)
        lpfb_pkg::ACT_WRITE: begin
          if (index < PIXEL_COUNT) drawing[index] = pack_pixel(red, green, blue);
        end
        lpfb_pkg::ACT_CLEAR: begin
          foreach (drawing[i]) drawing[i] = '0;
        end
        lpfb_pkg::ACT_FILL: begin
          fill_wheel(phase);
        end
        lpfb_pkg::ACT_LATCH: begin
          foreach (shown[i]) shown[i] = drawing[i];
        end
        lpfb_pkg::ACT_SEND: begin
          for (int unsigned i = 0; i < PIXEL_COUNT; i++) begin
            fw.word = shown[i];
            fw.position = 6'(i);
            fw.last = (i + 1 == PIXEL_COUNT);
            frame_words.push_back(fw);
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compares one strobed word with the oldest expected word.
    task check_word(logic [lpfb_pkg::WordW-1:0] word, logic [5:0] position, logic last);
      frame_word_t fw;
      words_seen++;
      if (frame_words.size() == 0) begin
        report_mismatch($sformatf("word %0d emitted with none expected", words_seen));
      end else begin
        fw = frame_words.pop_front();
        if (word !== fw.word)
          report_mismatch($sformatf("word %0d pixel_word %h, expected %h",
                                    words_seen, word, fw.word));
        if (position !== fw.position)
          report_mismatch($sformatf("word %0d pixel_position %0d, expected %0d",
                                    words_seen, position, fw.position));
        if (last !== fw.last)
          report_mismatch($sformatf("word %0d last_word %b, expected %b",
                                    words_seen, last, fw.last));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [2:0] action_i;
  logic [7:0] pixel_index_i;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic [7:0] phase_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [lpfb_pkg::GainW-1:0] cfg_data_i;
  logic out_strobe_o;
  logic [lpfb_pkg::WordW-1:0] pixel_word_o;
  logic [5:0] pixel_position_o;
  logic last_word_o;

  frame_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  logic [lpfb_pkg::GainW-1:0] phase_gain [NumPhases] = '{9'd0, 9'd1, 9'd128, 9'd255,
                                                         9'd511, 9'd257, 9'd200,
                                                         lpfb_pkg::FullScale};

  led_pixel_frame_buffer_core #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .pixel_index_i   (pixel_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .phase_i         (phase_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_strobe_o    (out_strobe_o),
    .pixel_word_o    (pixel_word_o),
    .pixel_position_o(pixel_position_o),
    .last_word_o     (last_word_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("led_pixel_frame_buffer_core test failed");
      $finish;
    end
  end

  // Every strobed word is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_strobe_o === 1'b1)
      sb.check_word(pixel_word_o, pixel_position_o, last_word_o);
  end

  // Holds a command on the port until the block takes it.
  task issue_command(logic [2:0] action, logic [7:0] index, logic [7:0] red,
                     logic [7:0] green, logic [7:0] blue, logic [7:0] phase);
    start_i <= 1'b1;
    action_i <= action;
    pixel_index_i <= index;
    red_i <= red;
    green_i <= green;
    blue_i <= blue;
    phase_i <= phase;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(action, index, red, green, blue, phase);
    items_sent++;
  endtask

  task idle_sender(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Optional random idle burst, then a command with random don't-care fields.
  task paced_command(bit idle_on, logic [2:0] action, logic [7:0] index,
                     logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    if (idle_on && $urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 7));
    issue_command(action, index, red, green, blue, 8'($urandom_range(0, 255)));
  endtask

  // Waits until the block is idle and every expected word has arrived.
  task wait_drained();
    start_i <= 1'b0;
    while (sb.pending() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_gain(logic [lpfb_pkg::GainW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_gain(value);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_index();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, PIXEL_COUNT - 1));
  endfunction

  // A well-formed frame: optional clear or fill, some writes, latch, send.
  task run_frame_sequence(bit idle_on);
    int unsigned n_writes;
    case ($urandom_range(0, 3))
      0: paced_command(idle_on, lpfb_pkg::ACT_CLEAR, random_index(), 8'($urandom),
                       8'($urandom), 8'($urandom));
      1: begin
        if (idle_on && $urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 7));
        issue_command(lpfb_pkg::ACT_FILL, random_index(), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
    n_writes = $urandom_range(1, 6);
    repeat (n_writes)
      paced_command(idle_on, lpfb_pkg::ACT_WRITE, random_index(),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
    paced_command(idle_on, lpfb_pkg::ACT_LATCH, random_index(), 8'($urandom), 8'($urandom),
                  8'($urandom));
    paced_command(idle_on, lpfb_pkg::ACT_SEND, random_index(), 8'($urandom), 8'($urandom),
                  8'($urandom));
  endtask

  // A single stray command of any code, unused codes included.
  task run_noise_item(bit idle_on);
    logic [2:0] action;
    if ($urandom_range(0, 3) == 0)
      action = 3'($urandom_range(ActCodeMax, lpfb_pkg::ACT_SEND + 1));
    else action = 3'($urandom_range(lpfb_pkg::ACT_SEND, lpfb_pkg::ACT_WRITE));
    paced_command(idle_on, action, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit idle_on;
    int unsigned target;
    sb = new();
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    action_i <= lpfb_pkg::ACT_WRITE;
    pixel_index_i <= '0;
    red_i <= '0;
    green_i <= '0;
    blue_i <= '0;
    phase_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty frame after reset, corner indexes, ignored writes,
    // unused codes, wheel segment boundaries and a cleared frame.
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    issue_command(lpfb_pkg::ACT_WRITE, 8'(PIXEL_COUNT - 1), 8'h80, 8'h01, 8'hFE, 8'd0);
    issue_command(lpfb_pkg::ACT_WRITE, 8'(PIXEL_COUNT), 8'hFF, 8'hFF, 8'hFF, 8'd0);
    issue_command(lpfb_pkg::ACT_WRITE, 8'hFF, 8'h12, 8'h34, 8'h56, 8'd0);
    issue_command(lpfb_pkg::ACT_WRITE, 8'd5, 8'hAA, 8'h55, 8'h0F, 8'd0);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(3'(lpfb_pkg::ACT_SEND + 1), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(ActCodeMax, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd85);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_LATCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue_command(lpfb_pkg::ACT_SEND, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // Random phases, one gain setting each; every third phase and the last run without idling.
    phase_gain[6] = 9'($urandom_range(2, 510));
    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_gain(phase_gain[p]);
      idle_on = (p + 1 < NumPhases) && (p % 3 != 2);
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) run_noise_item(idle_on);
        else run_frame_sequence(idle_on);
        if (idle_on && $urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("led_pixel_frame_buffer_core test passed");
    end else begin
      $display("led_pixel_frame_buffer_core test failed");
    end
    $finish;
  end

endmodule
